>>> hdl/ac_sample_filter_peak_meter_unit_macros.svh
// assertion macros used by the filter and peak meter top level
`ifndef AC_SAMPLE_FILTER_PEAK_METER_UNIT_MACROS_SVH
`define AC_SAMPLE_FILTER_PEAK_METER_UNIT_MACROS_SVH

// same-cycle implication
`define ACSFPM_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("acsfpm: same-cycle property failed");

// next-cycle implication
`define ACSFPM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("acsfpm: next-cycle property failed");

`endif

>>> hdl/acsfpm_pkg.sv
// types and constants of the sample filter and peak meter
package acsfpm_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int ACC_BITS      = SAMPLE_BITS + 16;
  localparam int SHIFT_BITS    = 4;
  localparam int WLEN_BITS     = 15;
  localparam int CFG_DATA_BITS = 15;
  localparam int CFG_IDX_BITS  = 1;
  localparam int COUNT_BITS    = 16;
  localparam int MM_BITS       = 16;
  localparam int MV_BITS       = 13;
  localparam int RMS_BITS      = 10;
  localparam int VAC_BITS      = 10;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_SHIFT  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 1'd1;

  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 4'd3;
  localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 15'd1000;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [SAMPLE_BITS-1:0] PEAK_MAX   = SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1));

  localparam logic signed [MM_BITS-1:0] ARM_MIN = 16'sd32000;
  localparam logic signed [MM_BITS-1:0] ARM_MAX = -16'sd32000;

  // input millivolts: trunc(peak * 2900 / 4096) * 2
  localparam int VIN_MUL_BITS = 12;
  localparam int VIN_SHIFT    = 12;
  localparam logic [VIN_MUL_BITS-1:0] VIN_MUL = 12'd2900;

  // constant division by rounded-up reciprocal, exact over the value range
  localparam longint VRMS_NUM      = 1000;
  localparam longint VRMS_DEN      = 7327;
  localparam int     VRMS_K        = 26;
  localparam int     VRMS_MUL_BITS = 24;
  localparam logic [VRMS_MUL_BITS-1:0] VRMS_MUL =
    VRMS_MUL_BITS'(((64'd1 << VRMS_K) * VRMS_NUM + VRMS_DEN - 1) / VRMS_DEN);

  localparam longint VAC_NUM      = 1000;
  localparam longint VAC_DEN      = 1400;
  localparam int     VAC_K        = 13;
  localparam int     VAC_MUL_BITS = 13;
  localparam logic [VAC_MUL_BITS-1:0] VAC_MUL =
    VAC_MUL_BITS'(((64'd1 << VAC_K) * VAC_NUM + VAC_DEN - 1) / VAC_DEN);

  localparam longint CUR_NUM      = 1000;
  localparam longint CUR_DEN      = 1008;
  localparam int     CUR_K        = 19;
  localparam int     CUR_MUL_BITS = 20;
  localparam logic [CUR_MUL_BITS-1:0] CUR_MUL =
    CUR_MUL_BITS'(((64'd1 << CUR_K) * CUR_NUM + CUR_DEN - 1) / CUR_DEN);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_ch0;
    logic [SAMPLE_BITS-1:0] sample_ch1;
    logic [SAMPLE_BITS-1:0] sample_ch2;
    logic [SAMPLE_BITS-1:0] sample_ch3;
  } in_beat_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered_ch0;
    logic [SAMPLE_BITS-1:0] filtered_ch1;
    logic [SAMPLE_BITS-1:0] filtered_ch2;
    logic [SAMPLE_BITS-1:0] filtered_ch3;
    logic [SAMPLE_BITS-1:0] volt_midpoint;
    logic [SAMPLE_BITS-1:0] volt_peak;
    logic [MV_BITS-1:0]     volt_in_mv;
    logic [RMS_BITS-1:0]    volt_rms;
    logic [VAC_BITS-1:0]    volt_ac;
    logic [SAMPLE_BITS-1:0] curr_midpoint;
    logic [SAMPLE_BITS-1:0] curr_peak;
    logic [SAMPLE_BITS-1:0] current_value;
  } out_beat_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] peak;
  } trk_result_t;

endpackage

>>> hdl/ac_sample_filter_peak_meter_unit.sv
// top level: four-channel moving average, peak meters and scaled readings
// throughput: one beat per cycle, set by the five-register pipeline with bubble
// collapse, while out_ready_i does not hold back a full pipeline
// stages: filter, trackers, two constant multiplies, then one multiply per later stage
// reset: accumulators and latched readings cleared, trackers re-armed, pipeline empty,
// filter_shift = 3 and window_length = 1000
`include "ac_sample_filter_peak_meter_unit_macros.svh"

module ac_sample_filter_peak_meter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  acsfpm_pkg::in_beat_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output acsfpm_pkg::out_beat_t                out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [acsfpm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [acsfpm_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import acsfpm_pkg::*;

  localparam int NUM_STAGES = 5;

  logic [SHIFT_BITS-1:0]  shift_q;
  logic [WLEN_BITS-1:0]   wlen_q;
  logic [NUM_STAGES-1:0]  v_q, ld;
  logic                   in_fire, trk_en;
  logic [SAMPLE_BITS-1:0] filt [4];
  trk_result_t            volt_res, curr_res;

  out_beat_t s0_q, s0_d, s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;

  logic [SAMPLE_BITS+VIN_MUL_BITS-1:0] vin_prod;
  logic [SAMPLE_BITS+CUR_MUL_BITS-1:0] cur_prod;
  logic [MV_BITS+VRMS_MUL_BITS-1:0]    vrms_prod;
  logic [RMS_BITS+VAC_MUL_BITS-1:0]    vac_prod;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
      wlen_q  <= WLEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_SHIFT:  shift_q <= cfg_wdata_i[SHIFT_BITS-1:0];
        CFG_WINDOW_LENGTH: wlen_q  <= cfg_wdata_i[WLEN_BITS-1:0];
      endcase
    end
  end

  // stage load enables
  always_comb begin
    ld[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign in_ready_o = ld[0];
  assign in_fire    = in_valid_i && ld[0];
  assign trk_en     = v_q[0] && ld[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  acsfpm_ema u_ema0 (
    .clk_i, .rst_ni, .en_i(in_fire), .sample_i(in_data_i.sample_ch0),
    .shift_i(shift_q), .filt_o(filt[0])
  );
  acsfpm_ema u_ema1 (
    .clk_i, .rst_ni, .en_i(in_fire), .sample_i(in_data_i.sample_ch1),
    .shift_i(shift_q), .filt_o(filt[1])
  );
  acsfpm_ema u_ema2 (
    .clk_i, .rst_ni, .en_i(in_fire), .sample_i(in_data_i.sample_ch2),
    .shift_i(shift_q), .filt_o(filt[2])
  );
  acsfpm_ema u_ema3 (
    .clk_i, .rst_ni, .en_i(in_fire), .sample_i(in_data_i.sample_ch3),
    .shift_i(shift_q), .filt_o(filt[3])
  );

  acsfpm_trk u_trk_volt (
    .clk_i, .rst_ni, .en_i(trk_en), .value_i(s0_q.filtered_ch3),
    .window_len_i(wlen_q), .res_o(volt_res)
  );
  acsfpm_trk u_trk_curr (
    .clk_i, .rst_ni, .en_i(trk_en), .value_i(s0_q.filtered_ch2),
    .window_len_i(wlen_q), .res_o(curr_res)
  );

  assign vin_prod  = (SAMPLE_BITS+VIN_MUL_BITS)'(s1_q.volt_peak)
                   * (SAMPLE_BITS+VIN_MUL_BITS)'(VIN_MUL);
  assign cur_prod  = (SAMPLE_BITS+CUR_MUL_BITS)'(s1_q.curr_peak)
                   * (SAMPLE_BITS+CUR_MUL_BITS)'(CUR_MUL);
  assign vrms_prod = (MV_BITS+VRMS_MUL_BITS)'(s2_q.volt_in_mv)
                   * (MV_BITS+VRMS_MUL_BITS)'(VRMS_MUL);
  assign vac_prod  = (RMS_BITS+VAC_MUL_BITS)'(s3_q.volt_rms)
                   * (RMS_BITS+VAC_MUL_BITS)'(VAC_MUL);

  always_comb begin
    s0_d              = '0;
    s0_d.filtered_ch0 = filt[0];
    s0_d.filtered_ch1 = filt[1];
    s0_d.filtered_ch2 = filt[2];
    s0_d.filtered_ch3 = filt[3];

    s1_d               = s0_q;
    s1_d.volt_midpoint = volt_res.mid;
    s1_d.volt_peak     = volt_res.peak;
    s1_d.curr_midpoint = curr_res.mid;
    s1_d.curr_peak     = curr_res.peak;

    s2_d               = s1_q;
    s2_d.volt_in_mv    = {vin_prod[VIN_SHIFT +: SAMPLE_BITS], 1'b0};
    s2_d.current_value = cur_prod[CUR_K +: SAMPLE_BITS];

    s3_d          = s2_q;
    s3_d.volt_rms = vrms_prod[VRMS_K +: RMS_BITS];

    s4_d         = s3_q;
    s4_d.volt_ac = vac_prod[VAC_K +: VAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_q <= s0_d;
    end
    if (ld[1]) begin
      s1_q <= s1_d;
    end
    if (ld[2]) begin
      s2_q <= s2_d;
    end
    if (ld[3]) begin
      s3_q <= s3_d;
    end
    if (ld[4]) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v_q[NUM_STAGES-1];
  assign out_data_o  = s4_q;

  `ACSFPM_ASSERT_IMPL(a_ready_when_drained, clk_i, rst_ni, !v_q[NUM_STAGES-1], in_ready_o)
  `ACSFPM_ASSERT_NEXT(a_out_fill, clk_i, rst_ni, v_q[NUM_STAGES-2] && ld[NUM_STAGES-1], out_valid_o)
  `ACSFPM_ASSERT_IMPL(a_peak_bound, clk_i, rst_ni, out_valid_o, (out_data_o.volt_peak <= PEAK_MAX) && (out_data_o.curr_peak <= PEAK_MAX))
  `ACSFPM_ASSERT_IMPL(a_scale_order, clk_i, rst_ni, out_valid_o, (out_data_o.volt_ac <= out_data_o.volt_rms) && (out_data_o.current_value <= out_data_o.curr_peak))

endmodule

>>> hdl/acsfpm_ema.sv
// shift-based exponential moving average for one channel
module acsfpm_ema (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [acsfpm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [acsfpm_pkg::SHIFT_BITS-1:0]  shift_i,
  output logic [acsfpm_pkg::SAMPLE_BITS-1:0] filt_o
);
  import acsfpm_pkg::*;

  logic [ACC_BITS-1:0] acc_q, acc_d, shifted;

  always_comb begin
    acc_d   = acc_q - (acc_q >> shift_i) + ACC_BITS'(sample_i);
    shifted = acc_d >> shift_i;
    if (shifted > ACC_BITS'(SAMPLE_MAX)) begin
      filt_o = SAMPLE_MAX;
    end else begin
      filt_o = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

>>> hdl/acsfpm_trk.sv
// windowed min/max tracker latching midpoint and peak
module acsfpm_trk (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [acsfpm_pkg::SAMPLE_BITS-1:0] value_i,
  input  logic [acsfpm_pkg::WLEN_BITS-1:0]   window_len_i,
  output acsfpm_pkg::trk_result_t            res_o
);
  import acsfpm_pkg::*;

  logic signed [MM_BITS-1:0] min_q, min_d, max_q, max_d;
  logic signed [MM_BITS-1:0] val_s, min_n, max_n, sum;
  logic [COUNT_BITS-1:0]     count_q, count_d;
  logic [SAMPLE_BITS-1:0]    mid_n, peak_n;
  logic                      close;
  trk_result_t               res_q, res_d;

  always_comb begin
    val_s  = $signed({{(MM_BITS - SAMPLE_BITS){1'b0}}, value_i});
    min_n  = (val_s < min_q) ? val_s : min_q;
    max_n  = (val_s > max_q) ? val_s : max_q;
    sum    = min_n + max_n;
    mid_n  = sum[SAMPLE_BITS:1];
    peak_n = max_n[SAMPLE_BITS-1:0] - mid_n;
    close  = count_q > COUNT_BITS'(window_len_i);

    min_d   = min_q;
    max_d   = max_q;
    count_d = count_q;
    res_d   = res_q;
    if (en_i) begin
      min_d   = min_n;
      max_d   = max_n;
      count_d = count_q + 1'b1;
      if (close) begin
        res_d.mid  = mid_n;
        res_d.peak = peak_n;
        min_d      = ARM_MIN;
        max_d      = ARM_MAX;
        count_d    = '0;
      end
    end
  end

  assign res_o = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= ARM_MIN;
      max_q   <= ARM_MAX;
      count_q <= '0;
      res_q   <= '0;
    end else begin
      min_q   <= min_d;
      max_q   <= max_d;
      count_q <= count_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> tb/tb_ac_sample_filter_peak_meter_unit.sv
// testbench of the four-channel sample filter and peak meter, checked beat by beat
module tb_ac_sample_filter_peak_meter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import acsfpm_pkg::*;

  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES      = 12;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] wdata;
    in_beat_t                 beat;
    logic                     typed;
    out_beat_t                want;
  } stim_row_t;

  typedef struct packed {
    int lo;
    int hi;
    int cnt;
    int mid;
    int pk;
  } window_trk_t;

  localparam window_trk_t WIN_ARMED = '{lo: int'(ARM_MIN), hi: int'(ARM_MAX),
                                        cnt: 0, mid: 0, pk: 0};

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  in_beat_t                 in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  out_beat_t                out_data_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  ac_sample_filter_peak_meter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // predictor state
  logic [ACC_BITS-1:0]   avg_acc [4];
  window_trk_t           volt_win;
  window_trk_t           curr_win;
  logic [SHIFT_BITS-1:0] cur_shift;
  logic [WLEN_BITS-1:0]  cur_wlen;
  out_beat_t             pending_readings [$];
  int                    mism       = 0;
  int                    out_count  = 0;
  int                    hold_token = 0;

  function automatic logic [SAMPLE_BITS-1:0] smooth(int ch, logic [SAMPLE_BITS-1:0] s);
    logic [ACC_BITS-1:0] a;
    logic [ACC_BITS-1:0] o;
    a = avg_acc[ch];
    a = a - (a >> cur_shift) + ACC_BITS'(s);
    avg_acc[ch] = a;
    o = a >> cur_shift;
    return (o > ACC_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX : o[SAMPLE_BITS-1:0];
  endfunction

  function automatic window_trk_t feed_window(window_trk_t t, int v);
    int prior;
    if (v < t.lo) t.lo = v;
    if (v > t.hi) t.hi = v;
    prior = t.cnt;
    t.cnt = (t.cnt + 1) & 32'hFFFF;
    if (prior > int'(cur_wlen)) begin
      t.mid = (t.lo + t.hi) / 2;
      t.pk  = t.hi - t.mid;
      t.lo  = WIN_ARMED.lo;
      t.hi  = WIN_ARMED.hi;
      t.cnt = 0;
    end
    return t;
  endfunction

  function automatic out_beat_t predict_readings(in_beat_t b);
    out_beat_t   r;
    int unsigned vp;
    int unsigned cp;
    int unsigned vin;
    int unsigned vrms;
    r.filtered_ch0 = smooth(0, b.sample_ch0);
    r.filtered_ch1 = smooth(1, b.sample_ch1);
    r.filtered_ch2 = smooth(2, b.sample_ch2);
    r.filtered_ch3 = smooth(3, b.sample_ch3);
    volt_win = feed_window(volt_win, int'(r.filtered_ch3));
    curr_win = feed_window(curr_win, int'(r.filtered_ch2));
    vp   = volt_win.pk;
    cp   = curr_win.pk;
    vin  = ((vp * 2900) / 4096) * 2;
    vrms = (vin * 1000) / 7327;
    r.volt_midpoint = SAMPLE_BITS'(volt_win.mid);
    r.volt_peak     = SAMPLE_BITS'(vp);
    r.volt_in_mv    = MV_BITS'(vin);
    r.volt_rms      = RMS_BITS'(vrms);
    r.volt_ac       = VAC_BITS'((vrms * 1000) / 1400);
    r.curr_midpoint = SAMPLE_BITS'(curr_win.mid);
    r.curr_peak     = SAMPLE_BITS'(cp);
    r.current_value = SAMPLE_BITS'((cp * 1000) / 1008);
    return r;
  endfunction

  function automatic out_beat_t flat_result(logic [SAMPLE_BITS-1:0] v);
    out_beat_t r;
    r = '0;
    r.filtered_ch0 = v;
    r.filtered_ch1 = v;
    r.filtered_ch2 = v;
    r.filtered_ch3 = v;
    return r;
  endfunction

  function automatic stim_row_t mk_beat(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b,
                                        logic [SAMPLE_BITS-1:0] c, logic [SAMPLE_BITS-1:0] d);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_BEAT;
    r.beat = '{a, b, c, d};
    return r;
  endfunction

  function automatic stim_row_t mk_typed(logic [SAMPLE_BITS-1:0] v, out_beat_t want);
    stim_row_t r;
    r       = mk_beat(v, v, v, v);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(logic [CFG_IDX_BITS-1:0] idx,
                                       logic [CFG_DATA_BITS-1:0] d);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.wdata = d;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] tri_wave(int k, int per, int amp);
    int ph;
    int half;
    int v;
    half = per / 2;
    ph   = k % per;
    if (ph > half) ph = per - ph;
    v = 2048 - amp + (2 * amp * ph) / half + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rail_or_random();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    out_beat_t p;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    p = predict_readings(b);
    pending_readings.push_back(typed ? want : p);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_readings();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FILTER_SHIFT) cur_shift = d[SHIFT_BITS-1:0];
    else cur_wlen = d[WLEN_BITS-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mism++;
      if (mism <= 10)
        $display("beat %0d %s: expected %0d, got %0d", out_count, name, want, got);
    end
  endtask

  // receiver: check each output beat, then pick ready for the next cycle
  int   stall_mode = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  int   hold_seen  = 0;
  logic rdy;

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_readings.size() == 0) begin
        mism++;
        if (mism <= 10) $display("beat %0d: output with nothing pending", out_count);
      end else begin
        out_beat_t w;
        w = pending_readings.pop_front();
        check_field("filtered_ch0", 16'(w.filtered_ch0), 16'(out_data_o.filtered_ch0));
        check_field("filtered_ch1", 16'(w.filtered_ch1), 16'(out_data_o.filtered_ch1));
        check_field("filtered_ch2", 16'(w.filtered_ch2), 16'(out_data_o.filtered_ch2));
        check_field("filtered_ch3", 16'(w.filtered_ch3), 16'(out_data_o.filtered_ch3));
        check_field("volt_midpoint", 16'(w.volt_midpoint), 16'(out_data_o.volt_midpoint));
        check_field("volt_peak", 16'(w.volt_peak), 16'(out_data_o.volt_peak));
        check_field("volt_in_mv", 16'(w.volt_in_mv), 16'(out_data_o.volt_in_mv));
        check_field("volt_rms", 16'(w.volt_rms), 16'(out_data_o.volt_rms));
        check_field("volt_ac", 16'(w.volt_ac), 16'(out_data_o.volt_ac));
        check_field("curr_midpoint", 16'(w.curr_midpoint), 16'(out_data_o.curr_midpoint));
        check_field("curr_peak", 16'(w.curr_peak), 16'(out_data_o.curr_peak));
        check_field("current_value", 16'(w.current_value), 16'(out_data_o.current_value));
      end
      out_count++;
    end
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (stall_left % 3 != 0);
      endcase
    end
    out_ready_i <= rdy;
  end

  // sender: directed rows, then random phases
  initial begin
    stim_row_t                dir_rows [$];
    in_beat_t                 b;
    logic [CFG_DATA_BITS-1:0] sd;
    int                       wl;
    int                       mode;
    int                       per;
    int                       amp_v;
    int                       amp_c;
    int                       n;
    int                       burst;
    logic                     gappy;

    foreach (avg_acc[i]) avg_acc[i] = '0;
    volt_win  = WIN_ARMED;
    curr_win  = WIN_ARMED;
    cur_shift = SHIFT_RESET;
    cur_wlen  = WLEN_RESET;

    dir_rows.push_back(mk_typed('0, flat_result('0)));
    dir_rows.push_back(mk_cfg(CFG_FILTER_SHIFT, 15'd0));
    dir_rows.push_back(mk_typed(SAMPLE_MAX, flat_result(SAMPLE_MAX)));
    dir_rows.push_back(mk_typed('0, flat_result('0)));
    dir_rows.push_back(mk_beat(12'hFFF, 12'h000, 12'hFFF, 12'h000));
    // window length dropped below the running count
    dir_rows.push_back(mk_cfg(CFG_WINDOW_LENGTH, 15'd0));
    dir_rows.push_back(mk_beat(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(mk_beat(12'h000, 12'h000, 12'h000, 12'h000));
    dir_rows.push_back(mk_beat(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(mk_beat(12'h555, 12'hAAA, 12'hAAA, 12'h555));
    dir_rows.push_back(mk_beat(12'hAAA, 12'h555, 12'h555, 12'hAAA));
    dir_rows.push_back(mk_beat(12'h000, 12'hFFF, 12'h000, 12'hFFF));
    // stray high bits above the shift field
    dir_rows.push_back(mk_cfg(CFG_FILTER_SHIFT, 15'h7FF8));
    dir_rows.push_back(mk_beat(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(mk_beat(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(mk_beat(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    // lowered shift saturates the filtered value
    dir_rows.push_back(mk_cfg(CFG_FILTER_SHIFT, 15'd1));
    dir_rows.push_back(mk_beat(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(mk_beat(12'h000, 12'h000, 12'h000, 12'h000));
    dir_rows.push_back(mk_cfg(CFG_FILTER_SHIFT, 15'd15));
    dir_rows.push_back(mk_cfg(CFG_WINDOW_LENGTH, 15'd32766));
    dir_rows.push_back(mk_beat(12'hFFF, 12'h000, 12'h800, 12'h7FF));
    dir_rows.push_back(mk_beat(12'h001, 12'hFFE, 12'h7FF, 12'h800));
    dir_rows.push_back(mk_cfg(CFG_FILTER_SHIFT, 15'(SHIFT_RESET)));
    dir_rows.push_back(mk_cfg(CFG_WINDOW_LENGTH, 15'(WLEN_RESET)));
    dir_rows.push_back(mk_beat(12'h123, 12'h456, 12'h789, 12'hABC));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_readings();
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        idle_gap($urandom_range(0, 2));
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_readings();
      if (ph == 0) sd = 15'h000F;
      else if (ph == 1) sd = 15'h7FF0;
      else sd = CFG_DATA_BITS'($urandom_range(0, 32767));
      write_reg(CFG_FILTER_SHIFT, sd);
      case ($urandom_range(0, 5))
        0: wl = 0;
        1: wl = 32766;
        2: wl = $urandom_range(100, 32766);
        default: wl = $urandom_range(1, 40);
      endcase
      write_reg(CFG_WINDOW_LENGTH, CFG_DATA_BITS'(wl));
      if (ph == 3 || ph == 8) hold_token++;
      mode  = $urandom_range(0, 9);
      per   = $urandom_range(8, 64);
      amp_v = $urandom_range(0, 2047);
      amp_c = $urandom_range(0, 2047);
      gappy = (ph % 4 != 1);
      n     = $urandom_range(60, 90);
      burst = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) begin
        if (mode <= 5) begin
          b.sample_ch0 = SAMPLE_BITS'($urandom_range(0, 4095));
          b.sample_ch1 = tri_wave(k, per, amp_v / 2);
          b.sample_ch2 = tri_wave(k + per / 4, per, amp_c);
          b.sample_ch3 = tri_wave(k, per, amp_v);
        end else if (mode <= 7) begin
          b = in_beat_t'({$urandom, $urandom});
        end else begin
          b = '{rail_or_random(), rail_or_random(), rail_or_random(), rail_or_random()};
        end
        send_beat(b, 1'b0, '0);
        burst = burst - 1;
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          if (gappy) idle_gap($urandom_range(1, 8));
        end
      end
    end

    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mism == 0 && pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/acsfpm_pkg.sv
hdl/acsfpm_ema.sv
hdl/acsfpm_trk.sv
hdl/ac_sample_filter_peak_meter_unit.sv
tb/tb_ac_sample_filter_peak_meter_unit.sv
